// ===== hdl/tfa_pkg.sv =====
// Shared types, codes and helper functions of the tagged frame allocator.
`default_nettype none

package tfa_pkg;

   // Field widths fixed by the interface
   localparam int KIND_W  = 2;
   localparam int OWNER_W = 16;
   localparam int FIDX_W  = 6;
   localparam int FCNT_W  = 7;
   localparam int SIDE_W  = 4;
   localparam int CSR_W   = 2;
   // Frame numbers, limits and counters: a 4-bit side gives at most 225 frames
   localparam int FRAME_W = 8;

   // Request kinds
   localparam logic [KIND_W-1:0] KIND_ALLOC     = 2'd0;
   localparam logic [KIND_W-1:0] KIND_REL_OWNER = 2'd1;
   localparam logic [KIND_W-1:0] KIND_REL_FRAME = 2'd2;

   // Classified operations handed to the back end
   localparam logic [1:0] OP_ALLOC     = 2'd0;
   localparam logic [1:0] OP_REL_OWNER = 2'd1;
   localparam logic [1:0] OP_REL_FRAME = 2'd2;
   localparam logic [1:0] OP_REJECT    = 2'd3;

   // Register indexes
   localparam logic [CSR_W-1:0] CSR_REAL_SIDE = 2'd0;
   localparam logic [CSR_W-1:0] CSR_SWAP_SIDE = 2'd1;

   // Store select
   localparam logic STORE_REAL = 1'b0;
   localparam logic STORE_SWAP = 1'b1;

   // Side value after reset
   localparam logic [SIDE_W-1:0] SIDE_RESET = 4'd8;

   // Command queue depth
   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic               store_select;
      logic [OWNER_W-1:0] owner_id;
      logic [FIDX_W-1:0]  frame_index;
   } req_type;

   typedef struct packed {
      logic [FIDX_W-1:0] frame_number;
      logic              ok;
      logic [FCNT_W-1:0] free_count;
   } rsp_type;

   typedef struct packed {
      logic [1:0]         op;
      logic               store;
      logic [OWNER_W-1:0] owner;
      logic [FRAME_W-1:0] frame;
      logic [FRAME_W-1:0] limit;
   } cmd_type;

   typedef struct packed {
      logic               en;
      logic               store;
      logic [FRAME_W-1:0] frames;
   } clear_type;

   // Zero reads as one, values above the maximum read as the maximum
   function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v,
                                                    input int max_side);
      logic [SIDE_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = 4'd1;
      end else if (int'(v) > max_side) begin
         r = SIDE_W'(max_side);
      end
      return r;
   endfunction

   // Frames in a store of the given side
   function automatic logic [FRAME_W-1:0] frames_of(input logic [SIDE_W-1:0] side);
      return {4'b0, side} * {4'b0, side};
   endfunction

endpackage

`default_nettype wire

// ===== hdl/tfa_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module tfa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/tfa_front.sv =====
// Front end: side registers, request classification and store clear requests.
`default_nettype none

module tfa_front #(
   parameter int MAX_SIDE   = 8,
   parameter int OWNER_BITS = 16
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [tfa_pkg::CSR_W-1:0]  csr_index,
   input  wire logic [tfa_pkg::SIDE_W-1:0] csr_data,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire tfa_pkg::req_type         req_data,
   output logic                          push_valid,
   input  wire logic                     push_ready,
   output tfa_pkg::cmd_type              push_cmd,
   output tfa_pkg::clear_type            clear
);

   localparam logic [tfa_pkg::SIDE_W-1:0] RESET_SIDE =
      tfa_pkg::clamp_side(tfa_pkg::SIDE_RESET, MAX_SIDE);
   localparam logic [tfa_pkg::OWNER_W-1:0] OWNER_MASK =
      (OWNER_BITS >= tfa_pkg::OWNER_W) ? {tfa_pkg::OWNER_W{1'b1}} :
      tfa_pkg::OWNER_W'((32'd1 << OWNER_BITS) - 32'd1);

   logic [tfa_pkg::SIDE_W-1:0]  real_side_ff, real_side_in;
   logic [tfa_pkg::SIDE_W-1:0]  swap_side_ff, swap_side_in;
   logic [tfa_pkg::SIDE_W-1:0]  wr_side;
   logic [tfa_pkg::FRAME_W-1:0] limit;
   logic                        csr_wr;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid & csr_ready;
   assign wr_side   = tfa_pkg::clamp_side(csr_data, MAX_SIDE);

   // Side register writes; a write also clears the store it names
   always_comb begin
      real_side_in = real_side_ff;
      swap_side_in = swap_side_ff;
      clear.en     = 1'b0;
      clear.store  = tfa_pkg::STORE_REAL;
      clear.frames = tfa_pkg::frames_of(wr_side);
      if (csr_wr) begin
         case (csr_index)
            tfa_pkg::CSR_REAL_SIDE: begin
               real_side_in = wr_side;
               clear.en     = 1'b1;
               clear.store  = tfa_pkg::STORE_REAL;
            end
            tfa_pkg::CSR_SWAP_SIDE: begin
               swap_side_in = wr_side;
               clear.en     = 1'b1;
               clear.store  = tfa_pkg::STORE_SWAP;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         real_side_ff <= RESET_SIDE;
         swap_side_ff <= RESET_SIDE;
      end else begin
         real_side_ff <= real_side_in;
         swap_side_ff <= swap_side_in;
      end
   end

   // Classify the request into a command
   assign limit = tfa_pkg::frames_of(req_data.store_select ? swap_side_ff : real_side_ff);

   always_comb begin
      push_cmd.store = req_data.store_select;
      push_cmd.owner = req_data.owner_id & OWNER_MASK;
      push_cmd.frame = {2'b0, req_data.frame_index};
      push_cmd.limit = limit;
      case (req_data.kind)
         tfa_pkg::KIND_ALLOC:     push_cmd.op = tfa_pkg::OP_ALLOC;
         tfa_pkg::KIND_REL_OWNER: push_cmd.op = tfa_pkg::OP_REL_OWNER;
         tfa_pkg::KIND_REL_FRAME: begin
            // out-of-range frame is rejected here
            push_cmd.op = ({2'b0, req_data.frame_index} < limit) ?
                          tfa_pkg::OP_REL_FRAME : tfa_pkg::OP_REJECT;
         end
         default:                 push_cmd.op = tfa_pkg::OP_REJECT;
      endcase
   end

   assign push_valid = req_valid;
   assign req_ready  = push_ready;

endmodule

`default_nettype wire

// ===== hdl/tfa_queue.sv =====
// Short command queue between the front end and the back end.
`default_nettype none

module tfa_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_valid,
   output logic                  push_ready,
   input  wire tfa_pkg::cmd_type push_cmd,
   output logic                  pop_valid,
   input  wire logic             pop_ready,
   output tfa_pkg::cmd_type      pop_cmd
);

   localparam int PTR_W = (tfa_pkg::QUEUE_DEPTH > 1) ? $clog2(tfa_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(tfa_pkg::QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(tfa_pkg::QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL = CNT_W'(tfa_pkg::QUEUE_DEPTH);

   tfa_pkg::cmd_type  slot_ff [tfa_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign push_ready = (count_ff != FULL);
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid & push_ready;
   assign do_pop     = pop_valid & pop_ready;

   // Pointer and fill update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Slot storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/tfa_back.sv =====
// Back end: free bitmaps, free counters, owner tag RAM, frame scans and result register.
`default_nettype none

module tfa_back #(
   parameter int MAX_SIDE   = 8,
   parameter int OWNER_BITS = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               pop_valid,
   output logic                    pop_ready,
   input  wire tfa_pkg::cmd_type   pop_cmd,
   input  wire tfa_pkg::clear_type clear,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output tfa_pkg::rsp_type        rsp_data
);

   localparam int FRAMES   = MAX_SIDE * MAX_SIDE;
   localparam int FRAME_AW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int TAG_W    = (OWNER_BITS < tfa_pkg::OWNER_W) ? OWNER_BITS : tfa_pkg::OWNER_W;
   localparam int RAM_D    = 2 ** (FRAME_AW + 1);
   localparam int FW       = tfa_pkg::FRAME_W;
   localparam logic [FW-1:0] RESET_FRAMES =
      tfa_pkg::frames_of(tfa_pkg::clamp_side(tfa_pkg::SIDE_RESET, MAX_SIDE));

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_ALLOC = 2'd1;
   localparam logic [1:0] ST_OWNER = 2'd2;

   logic [1:0]          state_ff, state_in;
   tfa_pkg::cmd_type    cmd_ff, cmd_in, cur;
   logic [FW-1:0]       scan_ff, scan_in;
   logic                chk_valid_ff, chk_valid_in;
   logic [FW-1:0]       chk_idx_ff, chk_idx_in;
   logic [FRAMES-1:0]   real_free_ff, real_free_in;
   logic [FRAMES-1:0]   swap_free_ff, swap_free_in;
   logic [FW-1:0]       real_cnt_ff, real_cnt_in;
   logic [FW-1:0]       swap_cnt_ff, swap_cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   tfa_pkg::rsp_type    rsp_data_ff, rsp_data_in;

   logic [FRAMES-1:0]   cur_free, free_nx;
   logic [FW-1:0]       cur_cnt, cnt_nx;
   logic [FW-1:0]       last_idx, res_frame;
   logic                finish, res_ok, issue;
   logic                tag_wr, tag_hit;
   logic [TAG_W-1:0]    tag_rd;

   // Command being worked on: straight from the queue when idle
   assign cur      = (state_ff == ST_IDLE) ? pop_cmd : cmd_ff;
   assign cur_free = (cur.store == tfa_pkg::STORE_SWAP) ? swap_free_ff : real_free_ff;
   assign cur_cnt  = (cur.store == tfa_pkg::STORE_SWAP) ? swap_cnt_ff : real_cnt_ff;
   assign last_idx = cur.limit - 1'b1;
   assign pop_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign issue    = (state_ff == ST_OWNER) && (scan_ff < cmd_ff.limit);
   assign tag_hit  = chk_valid_ff && !cur_free[chk_idx_ff[FRAME_AW-1:0]] &&
                     (tag_rd == cmd_ff.owner[TAG_W-1:0]);

   // Sequencer: single-step commands, allocate scan and owner scan
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      scan_in      = scan_ff;
      chk_valid_in = 1'b0;
      chk_idx_in   = scan_ff;
      free_nx      = cur_free;
      cnt_nx       = cur_cnt;
      finish       = 1'b0;
      res_ok       = 1'b0;
      res_frame    = '0;
      tag_wr       = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (pop_valid && pop_ready) begin
               cmd_in  = pop_cmd;
               scan_in = '0;
               case (pop_cmd.op)
                  tfa_pkg::OP_ALLOC:     state_in = ST_ALLOC;
                  tfa_pkg::OP_REL_OWNER: state_in = ST_OWNER;
                  tfa_pkg::OP_REL_FRAME: begin
                     finish    = 1'b1;
                     res_ok    = 1'b1;
                     res_frame = pop_cmd.frame;
                     // already free frames leave the counter alone
                     if (!cur_free[pop_cmd.frame[FRAME_AW-1:0]]) begin
                        free_nx[pop_cmd.frame[FRAME_AW-1:0]] = 1'b1;
                        cnt_nx = cur_cnt + 1'b1;
                     end
                  end
                  default: finish = 1'b1;
               endcase
            end
         end
         ST_ALLOC: begin
            // one frame per cycle, lowest first
            if (cur_free[scan_ff[FRAME_AW-1:0]]) begin
               free_nx[scan_ff[FRAME_AW-1:0]] = 1'b0;
               cnt_nx    = cur_cnt - 1'b1;
               tag_wr    = 1'b1;
               finish    = 1'b1;
               res_ok    = 1'b1;
               res_frame = scan_ff;
               state_in  = ST_IDLE;
            end else if (scan_ff == last_idx) begin
               finish   = 1'b1;
               state_in = ST_IDLE;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         ST_OWNER: begin
            // tag read issued in the cycle before its compare
            chk_valid_in = issue;
            scan_in      = scan_ff + FW'(issue);
            if (tag_hit) begin
               free_nx[chk_idx_ff[FRAME_AW-1:0]] = 1'b1;
               cnt_nx       = cur_cnt + 1'b1;
               finish       = 1'b1;
               res_ok       = 1'b1;
               res_frame    = chk_idx_ff;
               chk_valid_in = 1'b0;
               state_in     = ST_IDLE;
            end else if (chk_valid_ff && chk_idx_ff == last_idx) begin
               finish       = 1'b1;
               chk_valid_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Store state write-back on a finished command, with store clears from side writes on top
   always_comb begin
      real_free_in = real_free_ff;
      swap_free_in = swap_free_ff;
      real_cnt_in  = real_cnt_ff;
      swap_cnt_in  = swap_cnt_ff;
      if (finish) begin
         if (cur.store == tfa_pkg::STORE_SWAP) begin
            swap_free_in = free_nx;
            swap_cnt_in  = cnt_nx;
         end else begin
            real_free_in = free_nx;
            real_cnt_in  = cnt_nx;
         end
      end
      if (clear.en) begin
         if (clear.store == tfa_pkg::STORE_SWAP) begin
            swap_free_in = '1;
            swap_cnt_in  = clear.frames;
         end else begin
            real_free_in = '1;
            real_cnt_in  = clear.frames;
         end
      end
   end

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (finish) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.frame_number = res_ok ? res_frame[tfa_pkg::FIDX_W-1:0] : '0;
         rsp_data_in.ok           = res_ok;
         rsp_data_in.free_count   = cnt_nx[tfa_pkg::FCNT_W-1:0];
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         chk_valid_ff <= 1'b0;
         real_free_ff <= '1;
         swap_free_ff <= '1;
         real_cnt_ff  <= RESET_FRAMES;
         swap_cnt_ff  <= RESET_FRAMES;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         chk_valid_ff <= chk_valid_in;
         real_free_ff <= real_free_in;
         swap_free_ff <= swap_free_in;
         real_cnt_ff  <= real_cnt_in;
         swap_cnt_ff  <= swap_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      scan_ff     <= scan_in;
      chk_idx_ff  <= chk_idx_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Owner tags of both stores, addressed by store and frame
   tfa_ram #(
      .WIDTH (TAG_W),
      .DEPTH (RAM_D)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (tag_wr),
      .wr_addr ({cmd_ff.store, scan_ff[FRAME_AW-1:0]}),
      .wr_data (cmd_ff.owner[TAG_W-1:0]),
      .rd_en   (issue),
      .rd_addr ({cmd_ff.store, scan_ff[FRAME_AW-1:0]}),
      .rd_data (tag_rd)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== hdl/tagged_frame_allocator.sv =====
// Top level of the tagged frame allocator: front end, command queue and back end.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  req_data  (tfa_pkg::req_type)
//   rsp      out        rsp_valid / rsp_ready  rsp_data  (tfa_pkg::rsp_type)
//   csr      in         csr_valid / csr_ready  csr_index, csr_data (side registers)
//
// Back end, from the point an item leaves the queue: release by frame and rejected
// items are handled in the idle state with no scan; allocate scans from frame 0 up
// to the first free frame or the end of the store; release by owner scans for the
// lowest used frame with the tag, the one tag RAM read port scanning one frame a cycle.
// A two-entry command queue keeps accepting items while the back end scans or a result
// waits in the output register. Reset is synchronous and needs no clearing pass: free bits are flip-flops.
`default_nettype none

module tagged_frame_allocator #(
   parameter int MAX_SIDE   = 8,
   parameter int OWNER_BITS = 16
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire tfa_pkg::req_type           req_data,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output tfa_pkg::rsp_type                rsp_data,
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [tfa_pkg::CSR_W-1:0]  csr_index,
   input  wire logic [tfa_pkg::SIDE_W-1:0] csr_data
);

   logic               push_valid, push_ready;
   logic               pop_valid, pop_ready;
   tfa_pkg::cmd_type   push_cmd, pop_cmd;
   tfa_pkg::clear_type clear;

   // Classification and side registers
   tfa_front #(
      .MAX_SIDE   (MAX_SIDE),
      .OWNER_BITS (OWNER_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .clear      (clear)
   );

   // Decoupling queue
   tfa_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   // Frame stores and scans
   tfa_back #(
      .MAX_SIDE   (MAX_SIDE),
      .OWNER_BITS (OWNER_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_cmd   (pop_cmd),
      .clear     (clear),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ===== tb/tagged_frame_allocator_checker.sv =====
// Result checker of the tagged frame allocator: tracks both frame stores and compares results.
module tagged_frame_allocator_checker
   import tfa_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  req_type           req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  rsp_type           rsp_data,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic [CSR_W-1:0]  csr_index,
   input  logic [SIDE_W-1:0] csr_data,
   output int                pending,
   output int                mismatches,
   output int                checked,
   output int                refusals
);

   localparam int STORES     = 2;
   localparam int FRAMES_MAX = 64;
   localparam int SIDE_MAX   = 8;

   // Mirror of both stores
   logic               frame_free [STORES][FRAMES_MAX];
   logic [OWNER_W-1:0] owner_tag  [STORES][FRAMES_MAX];
   logic [FCNT_W-1:0]  free_total [STORES];
   logic [SIDE_W-1:0]  store_side [STORES];
   rsp_type            expected_rsp [$];
   int                 n_mismatch = 0;
   int                 n_checked  = 0;
   int                 n_refused  = 0;

   // Zero reads as one, anything above the maximum reads as the maximum
   function automatic logic [SIDE_W-1:0] effective_side(input logic [SIDE_W-1:0] v);
      if (v == '0) begin
         return SIDE_W'(1);
      end
      if (int'(v) > SIDE_MAX) begin
         return SIDE_W'(SIDE_MAX);
      end
      return v;
   endfunction

   // New geometry frees every frame; tags survive
   function automatic void clear_store(input int st, input logic [SIDE_W-1:0] v);
      store_side[st] = effective_side(v);
      for (int i = 0; i < FRAMES_MAX; i++) begin
         frame_free[st][i] = 1'b1;
      end
      free_total[st] = FCNT_W'(int'(store_side[st]) * int'(store_side[st]));
   endfunction

   // Apply one item to the mirror and return the result it should produce
   function automatic rsp_type serve_request(input req_type r);
      rsp_type res;
      int      st;
      int      frames;
      res    = '0;
      st     = int'(r.store_select);
      frames = int'(store_side[st]) * int'(store_side[st]);
      case (r.kind)
         KIND_ALLOC: begin
            // lowest free frame wins
            for (int i = 0; i < frames && !res.ok; i++) begin
               if (frame_free[st][i]) begin
                  frame_free[st][i] = 1'b0;
                  owner_tag[st][i]  = r.owner_id;
                  free_total[st]    = free_total[st] - 1'b1;
                  res.ok            = 1'b1;
                  res.frame_number  = FIDX_W'(i);
               end
            end
         end
         KIND_REL_OWNER: begin
            // lowest used frame carrying the tag
            for (int i = 0; i < frames && !res.ok; i++) begin
               if (!frame_free[st][i] && owner_tag[st][i] == r.owner_id) begin
                  frame_free[st][i] = 1'b1;
                  free_total[st]    = free_total[st] + 1'b1;
                  res.ok            = 1'b1;
                  res.frame_number  = FIDX_W'(i);
               end
            end
         end
         KIND_REL_FRAME: begin
            // already-free frame still succeeds, counter untouched
            if (int'(r.frame_index) < frames) begin
               if (!frame_free[st][r.frame_index]) begin
                  frame_free[st][r.frame_index] = 1'b1;
                  free_total[st]                = free_total[st] + 1'b1;
               end
               res.ok           = 1'b1;
               res.frame_number = r.frame_index;
            end
         end
         default: begin
         end
      endcase
      res.free_count = free_total[st];
      return res;
   endfunction

   task automatic compare_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         n_mismatch++;
      end
   endtask

   // Retire results first, then queue the prediction for a newly accepted item
   always @(posedge clock) begin : scoreboard
      rsp_type want;
      rsp_type got;
      if (reset) begin
         clear_store(int'(STORE_REAL), SIDE_RESET);
         clear_store(int'(STORE_SWAP), SIDE_RESET);
         expected_rsp.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = rsp_data;
            n_checked++;
            if (expected_rsp.size() == 0) begin
               $error("result with no item outstanding: frame_number %0d ok %0d free_count %0d",
                      got.frame_number, got.ok, got.free_count);
               n_mismatch++;
            end else begin
               want = expected_rsp.pop_front();
               compare_field("frame_number", want.frame_number, got.frame_number);
               compare_field("ok", want.ok, got.ok);
               compare_field("free_count", want.free_count, got.free_count);
            end
         end
         if (req_valid && req_ready) begin
            want = serve_request(req_data);
            if (!want.ok) begin
               n_refused++;
            end
            expected_rsp.push_back(want);
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_REAL_SIDE) begin
               clear_store(int'(STORE_REAL), csr_data);
            end else if (csr_index == CSR_SWAP_SIDE) begin
               clear_store(int'(STORE_SWAP), csr_data);
            end
         end
      end
      pending    <= expected_rsp.size();
      mismatches <= n_mismatch;
      checked    <= n_checked;
      refusals   <= n_refused;
   end

endmodule

// ===== tb/tagged_frame_allocator_tb.sv =====
// Testbench top of the tagged frame allocator: clock, reset, stimulus and verdict.
module tagged_frame_allocator_tb;
   import tfa_pkg::*;

   localparam int CYCLE_LIMIT = 600000;
   localparam int HOLD_CYCLES = 300;
   localparam int PHASES      = 10;
   localparam int PHASE_ITEMS = 78;
   localparam int POOL_SIZE   = 6;

   // Codes the package leaves unnamed
   localparam logic [KIND_W-1:0] KIND_UNKNOWN = 2'd3;
   localparam logic [CSR_W-1:0]  CSR_SPARE_A  = 2'd2;
   localparam logic [CSR_W-1:0]  CSR_SPARE_B  = 2'd3;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   req_type           req_data  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   rsp_type           rsp_data;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [CSR_W-1:0]  csr_index = '0;
   logic [SIDE_W-1:0] csr_data  = '0;

   int pending;
   int mismatches;
   int checked;
   int refusals;

   // Traffic control shared between the sender and the receiver
   bit req_gaps     = 1'b1;
   bit rsp_gaps     = 1'b1;
   bit hold_request = 1'b0;
   bit hold_active  = 1'b0;

   int                 cycle_count = 0;
   int                 items_sent  = 0;
   int                 side_writes = 0;
   int                 store_frames [2] = '{64, 64};
   logic [OWNER_W-1:0] owner_pool [POOL_SIZE];

   always #1 clock = ~clock;

   tagged_frame_allocator uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   tagged_frame_allocator_checker frame_check (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .pending    (pending),
      .mismatches (mismatches),
      .checked    (checked),
      .refusals   (refusals)
   );

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tagged_frame_allocator regression: fail");
         $finish;
      end
   end

   // Result side: ready bursts, random stalls, and one long hold-off on request
   initial begin : result_sink
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            hold_active  = 1'b1;
            rsp_ready   <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_active  = 1'b0;
         end else if (rsp_gaps && $urandom_range(0, 2) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clock);
         end
      end
   end

   function automatic req_type make_req(input logic [KIND_W-1:0] kind, input logic store,
                                        input logic [OWNER_W-1:0] owner,
                                        input logic [FIDX_W-1:0] idx);
      req_type r;
      r.kind         = kind;
      r.store_select = store;
      r.owner_id     = owner;
      r.frame_index  = idx;
      return r;
   endfunction

   // Mostly pooled owners and in-range frames so releases find something
   function automatic req_type random_request(input int alloc_pct);
      req_type r;
      int      roll;
      int      frames;
      roll           = $urandom_range(0, 99);
      r.store_select = 1'($urandom_range(0, 1));
      frames         = store_frames[r.store_select];
      if (roll < alloc_pct) begin
         r.kind = KIND_ALLOC;
      end else if (roll < alloc_pct + (100 - alloc_pct) / 2) begin
         r.kind = KIND_REL_OWNER;
      end else if (roll < 96) begin
         r.kind = KIND_REL_FRAME;
      end else begin
         r.kind = KIND_UNKNOWN;
      end
      if ($urandom_range(0, 9) < 8) begin
         r.owner_id = owner_pool[$urandom_range(0, POOL_SIZE - 1)];
      end else begin
         r.owner_id = 16'($urandom);
      end
      if ($urandom_range(0, 9) < 8) begin
         r.frame_index = 6'($urandom_range(0, frames - 1));
      end else begin
         r.frame_index = 6'($urandom_range(0, 63));
      end
      return r;
   endfunction

   // Offer one item, with an optional gap first; returns at the accepting edge
   task automatic push_req(input req_type item);
      if (req_gaps && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic release_req();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Stop offering and wait for every outstanding result
   task automatic drain();
      release_req();
      while (pending != 0) @(posedge clock);
   endtask

   task automatic write_side(input logic [CSR_W-1:0] idx, input logic [SIDE_W-1:0] v);
      int s;
      s = (v == '0) ? 1 : ((int'(v) > 8) ? 8 : int'(v));
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
      if (idx == CSR_REAL_SIDE) begin
         store_frames[STORE_REAL] = s * s;
      end else if (idx == CSR_SWAP_SIDE) begin
         store_frames[STORE_SWAP] = s * s;
      end
      side_writes++;
   endtask

   task automatic configure_stores(input logic [SIDE_W-1:0] real_v,
                                   input logic [SIDE_W-1:0] swap_v);
      if ($urandom_range(0, 1) == 1) begin
         write_side(CSR_REAL_SIDE, real_v);
         write_side(CSR_SWAP_SIDE, swap_v);
      end else begin
         write_side(CSR_SWAP_SIDE, swap_v);
         write_side(CSR_REAL_SIDE, real_v);
      end
   endtask

   initial begin : stimulus
      logic [SIDE_W-1:0] phase_real [PHASES];
      logic [SIDE_W-1:0] phase_swap [PHASES];
      int                alloc_pct;
      phase_real = '{4'd8, 4'd1, 4'd2, 4'd3, 4'd0, 4'd15, 4'd0, 4'd4, 4'd0, 4'd8};
      phase_swap = '{4'd8, 4'd2, 4'd3, 4'd8, 4'd15, 4'd0, 4'd0, 4'd5, 4'd0, 4'd8};
      phase_real[6] = 4'($urandom);
      phase_swap[6] = 4'($urandom);
      phase_real[8] = 4'($urandom);
      phase_swap[8] = 4'($urandom);

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Default geometry: allocate, release by owner and by frame, unknown kind
      push_req(make_req(KIND_ALLOC, STORE_REAL, 16'hFFFF, 6'd63));
      push_req(make_req(KIND_ALLOC, STORE_REAL, 16'h0000, 6'd0));
      push_req(make_req(KIND_ALLOC, STORE_SWAP, 16'h8001, 6'd0));
      push_req(make_req(KIND_REL_OWNER, STORE_REAL, 16'h0000, 6'd0));
      push_req(make_req(KIND_REL_OWNER, STORE_REAL, 16'h1234, 6'd0));   // no such owner
      push_req(make_req(KIND_REL_FRAME, STORE_REAL, 16'h0000, 6'd63));  // already free
      push_req(make_req(KIND_REL_FRAME, STORE_REAL, 16'h5555, 6'd0));
      push_req(make_req(KIND_REL_FRAME, STORE_REAL, 16'hAAAA, 6'd0));   // freed twice
      push_req(make_req(KIND_UNKNOWN, STORE_REAL, 16'hFFFF, 6'd63));
      push_req(make_req(KIND_UNKNOWN, STORE_SWAP, 16'h0000, 6'd0));
      push_req(make_req(KIND_REL_OWNER, STORE_SWAP, 16'h8001, 6'd0));
      drain();

      // One-frame stores, zero side included: full and out-of-range frames
      configure_stores(4'd1, 4'd0);
      push_req(make_req(KIND_ALLOC, STORE_REAL, 16'h0005, 6'd0));
      push_req(make_req(KIND_ALLOC, STORE_REAL, 16'h0006, 6'd0));
      push_req(make_req(KIND_REL_FRAME, STORE_REAL, 16'h0000, 6'd1));
      push_req(make_req(KIND_REL_FRAME, STORE_REAL, 16'h0000, 6'd63));
      push_req(make_req(KIND_ALLOC, STORE_SWAP, 16'h0007, 6'd0));
      push_req(make_req(KIND_ALLOC, STORE_SWAP, 16'h0008, 6'd0));
      drain();

      // Oversized sides clamp; the rewrite frees frames but keeps stale tags
      configure_stores(4'd15, 4'd9);
      write_side(CSR_SPARE_A, 4'd1);
      write_side(CSR_SPARE_B, 4'd2);
      push_req(make_req(KIND_REL_OWNER, STORE_REAL, 16'h0005, 6'd0));
      push_req(make_req(KIND_REL_FRAME, STORE_SWAP, 16'hFFFF, 6'd63));
      push_req(make_req(KIND_ALLOC, STORE_REAL, 16'h0009, 6'd0));
      push_req(make_req(KIND_REL_OWNER, STORE_REAL, 16'h0009, 6'd0));
      drain();

      // Random phases, each with its own geometry and owner pool
      for (int p = 0; p < PHASES; p++) begin
         for (int k = 0; k < POOL_SIZE; k++) begin
            owner_pool[k] = 16'($urandom);
         end
         alloc_pct = (p == PHASES - 1) ? 80 : $urandom_range(35, 80);
         if (p == PHASES - 1) begin
            req_gaps = 1'b0;
            rsp_gaps = 1'b0;
         end
         configure_stores(phase_real[p], phase_swap[p]);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (p == 2 && n == 20) begin
               // back-to-back items against a stalled result side
               release_req();
               req_gaps     = 1'b0;
               hold_request = 1'b1;
               while (!hold_active) @(posedge clock);
               repeat (12) push_req(random_request(alloc_pct));
               req_gaps = 1'b1;
            end
            if (p == 3 && n == 40) begin
               drain();
            end
            push_req(random_request(alloc_pct));
         end
         drain();
      end

      repeat (100) @(posedge clock);
      $display("Covered %0d items, %0d refused by the block, over %0d side register writes;",
               items_sent, refusals, side_writes);
      $display("%0d results checked, %0d mismatching.", checked, mismatches);
      if (mismatches == 0 && pending == 0) begin
         $display("tagged_frame_allocator regression: pass");
      end else begin
         $display("tagged_frame_allocator regression: fail");
      end
      $finish;
   end

endmodule
